// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the parser modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset.
`define EFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define EFP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== src/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, field tags, status codes and layout constants of the parser.
// ----------------------------------------------------------------------------
package efp_pkg;

    // Bytes in the fixed prefix: schema, type, sequence, stream, time.
    localparam int unsigned PrefixBytesInt = 2 + 2 + 8 + 8 + 8;
    localparam logic [4:0]  PREFIX_BYTES   = 5'(PrefixBytesInt);

    // Field tags (also the parser phase codes).
    localparam logic [3:0] TAG_SCHEMA   = 4'd0;
    localparam logic [3:0] TAG_TYPE     = 4'd1;
    localparam logic [3:0] TAG_SEQUENCE = 4'd2;
    localparam logic [3:0] TAG_STREAM   = 4'd3;
    localparam logic [3:0] TAG_TIME     = 4'd4;
    localparam logic [3:0] TAG_STR0_LEN = 4'd5;
    localparam logic [3:0] TAG_STR0     = 4'd6;
    localparam logic [3:0] TAG_STR1_LEN = 4'd7;
    localparam logic [3:0] TAG_STR1     = 4'd8;
    localparam logic [3:0] TAG_STR2_LEN = 4'd9;
    localparam logic [3:0] TAG_STR2     = 4'd10;
    localparam logic [3:0] TAG_PAY_LEN  = 4'd11;
    localparam logic [3:0] TAG_PAYLOAD  = 4'd12;
    localparam logic [3:0] TAG_EXCESS   = 4'd13;

    // Final status codes.
    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_BAD_SCHEMA = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;
    localparam logic [2:0] ST_TRAILING  = 3'd6;

    // One result transfer; the last field sits in the lowest bits.
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] field_value;
        logic        field_complete;
        logic [31:0] byte_offset;
        logic [7:0]  byte_out;
        logic [3:0]  field_tag;
    } efp_result_t;

    // Byte width of the fixed and length fields; zero for variable fields.
    function automatic logic [3:0] fixed_width(input logic [3:0] phase);
        logic [3:0] w;
        case (phase)
            TAG_SCHEMA, TAG_TYPE, TAG_STR0_LEN, TAG_STR1_LEN, TAG_STR2_LEN: w = 4'd2;
            TAG_SEQUENCE, TAG_STREAM, TAG_TIME: w = 4'd8;
            TAG_PAY_LEN: w = 4'd4;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== src/efp_core.sv =====
// ----------------------------------------------------------------------------
// efp_core
// Parse state registers and the combinational per-byte step logic.
// ----------------------------------------------------------------------------
module efp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [15:0]          expected_schema,
    input  logic [15:0]          accepted_type,
    output efp_pkg::efp_result_t result
);
    import efp_pkg::*;

    logic [3:0]  phase_reg,  phase_next;
    logic [31:0] count_reg,  count_next;
    logic [31:0] length_reg, length_next;
    logic [63:0] acc_reg,    acc_next;
    logic [4:0]  prefix_reg, prefix_next;
    logic [2:0]  error_reg,  error_next;

    logic [3:0]  ph_cur;
    logic [3:0]  width;
    logic [31:0] count_inc;
    logic [63:0] acc_shift;
    logic        complete;
    logic [63:0] value;
    logic [2:0]  status;

    assign ph_cur    = (phase_reg > TAG_EXCESS) ? TAG_EXCESS : phase_reg;
    assign width     = fixed_width(phase_reg);
    assign count_inc = count_reg + 32'd1;
    assign acc_shift = acc_reg | (64'(data_byte) << {count_reg[2:0], 3'b000});

    always_comb begin
        phase_next  = ph_cur;
        count_next  = count_inc;
        length_next = length_reg;
        acc_next    = acc_reg;
        error_next  = error_reg;
        prefix_next = (prefix_reg < PREFIX_BYTES) ? prefix_reg + 5'd1 : prefix_reg;
        complete    = 1'b0;
        value       = '0;
        status      = ST_PENDING;

        if (width != 4'd0) begin
            acc_next = acc_shift;
            if (count_inc >= 32'(width)) begin
                complete   = 1'b1;
                value      = acc_shift;
                acc_next   = '0;
                count_next = '0;
                case (ph_cur)
                    TAG_SCHEMA: begin
                        if (acc_shift[15:0] != expected_schema && error_reg == ST_PENDING)
                            error_next = ST_BAD_SCHEMA;
                        phase_next = TAG_TYPE;
                    end
                    TAG_TYPE: begin
                        if (acc_shift[15:0] != accepted_type && error_reg == ST_PENDING)
                            error_next = ST_BAD_TYPE;
                        phase_next = TAG_SEQUENCE;
                    end
                    TAG_STR0_LEN, TAG_STR1_LEN, TAG_STR2_LEN: begin
                        length_next = {16'd0, acc_shift[15:0]};
                        phase_next  = (acc_shift[15:0] != 16'd0) ? ph_cur + 4'd1
                                                                 : ph_cur + 4'd2;
                    end
                    TAG_PAY_LEN: begin
                        length_next = acc_shift[31:0];
                        phase_next  = (acc_shift[31:0] != 32'd0) ? TAG_PAYLOAD : TAG_EXCESS;
                    end
                    default: begin
                        // sequence, stream, time
                        phase_next = ph_cur + 4'd1;
                    end
                endcase
            end
        end else if (ph_cur inside {TAG_STR0, TAG_STR1, TAG_STR2, TAG_PAYLOAD}) begin
            if (count_inc >= length_reg) begin
                count_next = '0;
                phase_next = (ph_cur == TAG_PAYLOAD) ? TAG_EXCESS : ph_cur + 4'd1;
            end
        end

        if (last_byte) begin
            if (prefix_next < PREFIX_BYTES)  status = ST_TRUNCATED;
            else if (error_next != ST_PENDING) status = error_next;
            else if (phase_reg >= TAG_EXCESS) status = ST_TRAILING;
            else if (phase_next == TAG_EXCESS) status = ST_OK;
            else if (phase_next == TAG_PAYLOAD) status = ST_OVERFLOW;
            else                              status = ST_TRUNCATED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_byte)) begin
            phase_reg  <= TAG_SCHEMA;
            count_reg  <= '0;
            length_reg <= '0;
            acc_reg    <= '0;
            prefix_reg <= '0;
            error_reg  <= ST_PENDING;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            acc_reg    <= acc_next;
            prefix_reg <= prefix_next;
            error_reg  <= error_next;
        end
    end

    assign result.field_tag      = ph_cur;
    assign result.byte_out       = data_byte;
    assign result.byte_offset    = count_reg;
    assign result.field_complete = complete;
    assign result.field_value    = value;
    assign result.status         = status;

`include "assert_macros.svh"

    `EFP_ASSERT(a_prefix_sat, prefix_reg <= PREFIX_BYTES, "prefix count past saturation")
    `EFP_ASSERT(a_error_code, error_reg == ST_PENDING || error_reg == ST_BAD_SCHEMA || error_reg == ST_BAD_TYPE, "latched error is not a header error")
    `EFP_ASSERT(a_clear_after_last, step_en && last_byte |=> phase_reg == TAG_SCHEMA && count_reg == 32'd0 && error_reg == ST_PENDING && prefix_reg == 5'd0, "parse state not cleared after final byte")
    `EFP_ASSERT(a_value_zero, !complete |-> value == 64'd0, "field value set without a completed field")

endmodule

// ===== src/efp_out_stage.sv =====
// ----------------------------------------------------------------------------
// efp_out_stage
// Result register between the parse step and the master stream port.
// ----------------------------------------------------------------------------
module efp_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_en,
    input  efp_pkg::efp_result_t result_in,
    input  logic                 last_in,
    output logic                 load_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output efp_pkg::efp_result_t result_out,
    output logic                 last_out
);
    import efp_pkg::*;

    logic        valid_reg, valid_next;
    efp_result_t result_reg;
    logic        last_reg;

    // Take a new result when empty or when the held one leaves this cycle.
    assign load_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load_en)      valid_next = 1'b1;
        else if (m_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            result_reg <= result_in;
            last_reg   <= last_in;
        end
    end

    assign m_valid    = valid_reg;
    assign result_out = result_reg;
    assign last_out   = last_reg;

`include "assert_macros.svh"

    `EFP_ASSERT_ALWAYS(a_stall_only_full, !load_ready |-> valid_reg, "input stalled with an empty result register")
    `EFP_ASSERT(a_load_sets_valid, load_en |=> valid_reg, "loaded result not marked valid")

endmodule

// ===== src/envelope_frame_parser.sv =====
// ----------------------------------------------------------------------------
// envelope_frame_parser
// Byte-stream parser for one little-endian framed message per tlast run.
// ----------------------------------------------------------------------------
// Feed the message one byte per transfer on the slave stream, with tlast on
// its final byte. Every byte comes back on the master stream, registered,
// tagged with its field and its offset in that field; the byte that finishes
// a fixed or length field also carries the assembled value. The final byte
// carries the message status (ok, truncated, bad schema, unknown type, length
// overflow, trailing bytes) and tlast; all other bytes report pending. Header
// errors are latched but do not stop the walk through the layout. The block
// takes one byte per clock while its single result register keeps loading,
// which it does while it is empty or the downstream side accepts. When a
// result is waiting and m_axis_tready is low, the result
// register holds and the input stalls; an empty result register still takes
// a byte. Write the two configuration registers (index 0: expected schema,
// index 1: accepted message type) only between messages; they keep their
// values across messages and reset to 1 and 0.
// ----------------------------------------------------------------------------
module envelope_frame_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // [3:0] field_tag, [11:4] byte_out,
                                         // [43:12] byte_offset, [44] field_complete,
                                         // [108:45] field_value, [111:109] status
    output logic         m_axis_tlast    // message_end
);
    import efp_pkg::*;

    localparam logic [7:0] CFG_SCHEMA = 8'd0;
    localparam logic [7:0] CFG_TYPE   = 8'd1;

    logic [15:0] schema_reg;
    logic [15:0] type_reg;
    logic        in_fire;
    efp_result_t step_result;
    efp_result_t out_result;

    // Configuration registers: plain writes, addresses outside the map ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            schema_reg <= 16'd1;
            type_reg   <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SCHEMA: schema_reg <= cfg_wdata;
                CFG_TYPE:   type_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the parse state on every accepted transfer.
    assign in_fire = s_axis_tvalid && s_axis_tready;

    efp_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (in_fire),
        .data_byte       (s_axis_tdata),
        .last_byte       (s_axis_tlast),
        .expected_schema (schema_reg),
        .accepted_type   (type_reg),
        .result          (step_result)
    );

    // Hold the finished result until the master side takes it.
    efp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (in_fire),
        .result_in  (step_result),
        .last_in    (s_axis_tlast),
        .load_ready (s_axis_tready),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .result_out (out_result),
        .last_out   (m_axis_tlast)
    );

    assign m_axis_tdata = out_result;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the envelope frame parser.
// ----------------------------------------------------------------------------
// Builds framed messages byte by byte and streams them into the parser. The
// messages are well formed, cut short, carry trailing bytes, hold bad header
// values, declare huge lengths, or are plain noise. A scoreboard class walks
// the same layout for every accepted byte, queues the tagged byte it should
// produce, and compares each result transfer field by field. The run goes
// through several configuration settings and several idling patterns on
// both streams, including one long downstream hold-off that backs up the
// input side.
// ----------------------------------------------------------------------------
module tb;
    import efp_pkg::*;

    // Configuration register indexes.
    localparam logic [7:0]  CFG_SCHEMA  = 8'd0;
    localparam logic [7:0]  CFG_TYPE    = 8'd1;

    localparam int unsigned NO_CUT      = 32'hFFFF_FFFF;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_BYTES = 140;
    localparam int unsigned NUM_PHASES  = 5;
    localparam int unsigned LIMIT_NS    = 4_000_000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One expected result transfer: the tdata fields plus tlast.
    typedef struct packed {
        logic        last;
        efp_result_t res;
    } parsed_byte_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the layout walk and holds the tagged bytes to come.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [15:0]  schema_cfg = 16'h0001;
        logic [15:0]  type_cfg   = 16'h0000;
        logic [3:0]   phase;
        logic [31:0]  byte_count;
        logic [31:0]  run_length;
        logic [63:0]  shift_in;
        logic [4:0]   prefix_seen;
        logic [2:0]   first_error;
        parsed_byte_t expected_bytes[$];
        int unsigned  errors;
        int unsigned  checked;

        function new();
            restart();
            errors  = 0;
            checked = 0;
        endfunction

        function void restart();
            phase       = TAG_SCHEMA;
            byte_count  = '0;
            run_length  = '0;
            shift_in    = '0;
            prefix_seen = '0;
            first_error = ST_PENDING;
        endfunction

        function void set_register(logic [7:0] index, logic [15:0] value);
            if (index == CFG_SCHEMA) schema_cfg = value;
            else if (index == CFG_TYPE) type_cfg = value;
        endfunction

        // Bytes in a fixed or length field; zero for strings, payload, excess.
        function logic [3:0] header_width(logic [3:0] tag);
            case (tag)
                TAG_SEQUENCE, TAG_STREAM, TAG_TIME: return 4'd8;
                TAG_PAY_LEN: return 4'd4;
                TAG_SCHEMA, TAG_TYPE, TAG_STR0_LEN, TAG_STR1_LEN, TAG_STR2_LEN: return 4'd2;
                default: return 4'd0;
            endcase
        endfunction

        // Advance the layout walk by one accepted byte and queue its result.
        function void note_byte(logic [7:0] value, logic last);
            logic [3:0]   entry_phase;
            logic [3:0]   ph;
            logic [31:0]  offset;
            logic [3:0]   width;
            logic [63:0]  assembled;
            parsed_byte_t r;
            entry_phase = phase;
            ph          = (entry_phase > TAG_EXCESS) ? TAG_EXCESS : entry_phase;
            offset      = byte_count;
            width       = header_width(ph);
            if (prefix_seen < PREFIX_BYTES) prefix_seen++;
            r                 = '0;
            r.last            = last;
            r.res.field_tag   = ph;
            r.res.byte_out    = value;
            r.res.byte_offset = offset;
            if (width != 0) begin
                shift_in |= 64'(value) << (8 * offset[2:0]);
                if (offset + 32'd1 >= 32'(width)) begin
                    assembled            = shift_in;
                    r.res.field_complete = 1'b1;
                    r.res.field_value    = assembled;
                    shift_in             = '0;
                    offset               = '0;
                    case (ph)
                        TAG_SCHEMA: begin
                            if (assembled[15:0] != schema_cfg && first_error == ST_PENDING)
                                first_error = ST_BAD_SCHEMA;
                            ph = TAG_TYPE;
                        end
                        TAG_TYPE: begin
                            if (assembled[15:0] != type_cfg && first_error == ST_PENDING)
                                first_error = ST_BAD_TYPE;
                            ph = TAG_SEQUENCE;
                        end
                        TAG_SEQUENCE, TAG_STREAM, TAG_TIME: begin
                            ph = ph + 4'd1;
                        end
                        TAG_STR0_LEN, TAG_STR1_LEN, TAG_STR2_LEN: begin
                            run_length = {16'd0, assembled[15:0]};
                            // an empty string skips straight to the next length
                            ph = (run_length != 0) ? ph + 4'd1 : ph + 4'd2;
                        end
                        default: begin
                            run_length = assembled[31:0];
                            ph = (run_length != 0) ? TAG_PAYLOAD : TAG_EXCESS;
                        end
                    endcase
                end else begin
                    offset++;
                end
            end else if (ph == TAG_STR0 || ph == TAG_STR1 || ph == TAG_STR2
                         || ph == TAG_PAYLOAD) begin
                if (offset + 32'd1 >= run_length) begin
                    offset = '0;
                    ph     = (ph == TAG_PAYLOAD) ? TAG_EXCESS : ph + 4'd1;
                end else begin
                    offset++;
                end
            end else begin
                offset++;
            end
            phase      = ph;
            byte_count = offset;
            if (last) begin
                if (prefix_seen < PREFIX_BYTES) r.res.status = ST_TRUNCATED;
                else if (first_error != ST_PENDING) r.res.status = first_error;
                else if (entry_phase >= TAG_EXCESS) r.res.status = ST_TRAILING;
                else if (ph == TAG_EXCESS) r.res.status = ST_OK;
                else if (ph == TAG_PAYLOAD) r.res.status = ST_OVERFLOW;
                else r.res.status = ST_TRUNCATED;
                restart();
            end
            expected_bytes.insert(expected_bytes.size(), r);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %0h, got %0h", checked, what, want, got);
        endfunction

        // Compare one result transfer with the oldest queued byte.
        function void check_result(efp_result_t got, logic got_last);
            parsed_byte_t want;
            checked++;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: transfer %0h arrived with nothing queued",
                             checked, got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.field_tag !== want.res.field_tag)
                flag("field_tag", want.res.field_tag, got.field_tag);
            if (got.byte_out !== want.res.byte_out)
                flag("byte_out", want.res.byte_out, got.byte_out);
            if (got.byte_offset !== want.res.byte_offset)
                flag("byte_offset", want.res.byte_offset, got.byte_offset);
            if (got.field_complete !== want.res.field_complete)
                flag("field_complete", want.res.field_complete, got.field_complete);
            if (got.field_value !== want.res.field_value)
                flag("field_value", want.res.field_value, got.field_value);
            if (got.status !== want.res.status)
                flag("status", want.res.status, got.status);
            if (got_last !== want.last)
                flag("message_end", want.last, got_last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         cfg_wr_en     = 1'b0;
    logic [7:0]   cfg_addr      = '0;
    logic [15:0]  cfg_wdata     = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;
    logic         s_axis_tlast  = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;
    logic         m_axis_tlast;

    envelope_frame_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    frame_scoreboard frames = new();
    idle_mode_t      idle_mode = IDLE_NONE;
    bit              hold_req  = 1'b0;
    int unsigned     hold_left = 0;
    int unsigned     bytes_sent = 0;
    logic [7:0]      frame_q[$];

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Result side: drive tready at the falling edge, check at the rising edge.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        // Load a long hold-off on request; count it down here so the sender
        // keeps pushing and the parser has to stall its input.
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: m_axis_tready <= ($urandom_range(0, 99) >= 81);
                IDLE_BOTH:     m_axis_tready <= ($urandom_range(0, 99) >= 37);
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            frames.check_result(efp_result_t'(m_axis_tdata), m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 81;
            IDLE_BOTH:   return $urandom_range(0, 99) < 37;
            default:     return 1'b0;
        endcase
    endfunction

    // Offer one byte and hold it until the parser takes the transfer.
    task automatic send_byte(input logic [7:0] value, input logic last);
        @(negedge aclk);
        while (sender_rests()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        frames.note_byte(value, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Drop tvalid and wait until every queued result is out.
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (frames.expected_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [7:0] index, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        frames.set_register(index, value);
    endtask

    // ------------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------------
    // Append one byte at the tail of the frame under construction.
    function automatic void append_byte(input logic [7:0] value);
        frame_q.insert(frame_q.size(), value);
    endfunction

    function automatic void put_le(input logic [63:0] value, input int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++)
            append_byte(value[8*i +: 8]);
    endfunction

    // Random content; stop at the cut point so huge lengths stay cheap.
    function automatic void put_fill(input logic [31:0] count, input int unsigned cap);
        for (longint unsigned i = 0; i < count && frame_q.size() < cap; i++)
            append_byte(8'($urandom));
    endfunction

    function automatic void build_frame(input logic [15:0] schema, input logic [15:0] mtype,
                                        input logic [15:0] len0, input logic [15:0] len1,
                                        input logic [15:0] len2, input logic [31:0] pay_len,
                                        input int unsigned extra, input int unsigned cap);
        frame_q.delete();
        put_le(schema, 2);
        put_le(mtype, 2);
        put_fill(24, cap);
        put_le(len0, 2);
        put_fill(len0, cap);
        put_le(len1, 2);
        put_fill(len1, cap);
        put_le(len2, 2);
        put_fill(len2, cap);
        put_le(pay_len, 4);
        put_fill(pay_len, cap);
        put_fill(extra, cap);
        while (frame_q.size() > cap) void'(frame_q.pop_back());
    endfunction

    function automatic logic [15:0] short_len();
        if ($urandom_range(0, 9) == 0) return 16'($urandom_range(4, 12));
        return 16'($urandom_range(0, 3));
    endfunction

    // Mostly well-formed frames with random content; the rest cut, padded,
    // mis-headed, oversized or plain noise.
    task automatic random_frame();
        int unsigned pick;
        int unsigned full;
        int unsigned cap;
        int unsigned extra;
        logic [15:0] schema;
        logic [15:0] mtype;
        logic [15:0] len0;
        logic [15:0] len1;
        logic [15:0] len2;
        logic [31:0] pay_len;
        pick    = $urandom_range(0, 99);
        schema  = frames.schema_cfg;
        mtype   = frames.type_cfg;
        len0    = short_len();
        len1    = short_len();
        len2    = short_len();
        pay_len = 32'($urandom_range(0, 6));
        full    = 38 + len0 + len1 + len2 + pay_len;
        extra   = 0;
        cap     = NO_CUT;
        if (pick < 55) begin
            // well formed
        end else if (pick < 65) begin
            extra = $urandom_range(1, 4);
        end else if (pick < 72) begin
            cap = $urandom_range(28, full - 1);
        end else if (pick < 78) begin
            cap = $urandom_range(1, 27);
        end else if (pick < 84) begin
            schema ^= 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 1) == 1) mtype ^= 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 2) == 0) extra = $urandom_range(1, 3);
        end else if (pick < 90) begin
            mtype ^= 16'($urandom_range(1, 65535));
        end else if (pick < 95) begin
            // Oversized length, cut long before it could be honored.
            case ($urandom_range(0, 3))
                0:       len0 = 16'($urandom) | 16'h0100;
                1:       len1 = 16'($urandom) | 16'h0100;
                2:       len2 = 16'($urandom) | 16'h0100;
                default: pay_len = $urandom | 32'h0000_0100;
            endcase
            cap = $urandom_range(28, 70);
        end
        if (pick >= 95) begin
            frame_q.delete();
            repeat ($urandom_range(1, 60)) append_byte(8'($urandom));
        end else begin
            build_frame(schema, mtype, len0, len1, len2, pay_len, extra, cap);
        end
        send_frame();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] schema;
        logic [15:0] mtype;
        int unsigned quota;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        drain();
        write_register(CFG_SCHEMA, 16'h0001);
        write_register(CFG_TYPE, 16'h0000);

        // Directed frames: clean walk with all lengths empty, clean walk with
        // content, header errors (schema wins over type), short frames around
        // the prefix boundary, trailing bytes, payload overflow and a string
        // length far beyond the frame.
        build_frame(16'h0001, 16'h0000, 0, 0, 0, 0, 0, NO_CUT);
        send_frame();
        build_frame(16'h0001, 16'h0000, 1, 2, 3, 4, 0, NO_CUT);
        send_frame();
        build_frame(16'hFFFF, 16'hFFFF, 0, 1, 0, 1, 0, NO_CUT);
        send_frame();
        build_frame(16'h0001, 16'h8000, 1, 0, 0, 2, 0, NO_CUT);
        send_frame();
        build_frame(16'h0001, 16'h0000, 0, 0, 0, 0, 0, 1);
        send_frame();
        build_frame(16'h0001, 16'h0000, 0, 0, 0, 0, 0, 27);
        send_frame();
        build_frame(16'h0001, 16'h0000, 0, 0, 0, 0, 0, 28);
        send_frame();
        build_frame(16'h0001, 16'h0000, 0, 0, 2, 3, 2, NO_CUT);
        send_frame();
        build_frame(16'h0001, 16'h0000, 0, 0, 0, 32'hFFFF_FFFF, 0, 41);
        send_frame();
        build_frame(16'h0001, 16'h0000, 16'hFFFF, 0, 0, 0, 0, 35);
        send_frame();

        // Random phases, each setting the registers and an idling mode before it runs.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin schema = 16'hFFFF; mtype = 16'hFFFF; end
                1: begin schema = 16'h0000; mtype = 16'h0000; end
                3: begin schema = 16'h0001; mtype = 16'hFFFF; end
                default: begin schema = 16'($urandom); mtype = 16'($urandom); end
            endcase
            drain();
            write_register(CFG_SCHEMA, schema);
            write_register(CFG_TYPE, mtype);
            case (p)
                1:       idle_mode = IDLE_SENDER;
                2:       idle_mode = IDLE_RECEIVER;
                3:       idle_mode = IDLE_BOTH;
                default: idle_mode = IDLE_NONE;
            endcase
            // Back up the result side once while the sender runs flat out.
            if (p == 0) hold_req = 1'b1;
            quota = bytes_sent + PHASE_BYTES;
            while (bytes_sent < quota) random_frame();
        end

        idle_mode = IDLE_NONE;
        drain();
        repeat (10) @(posedge aclk);
        if (frames.errors == 0 && frames.expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
